/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the ASCII-to-integer parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ATIP_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ATIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ATIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/atip_pkg.sv */
// ----------------------------------------------------------------------------
// atip_pkg
// Types and constants of the ASCII-to-integer parser.
// ----------------------------------------------------------------------------
package atip_pkg;

  localparam int unsigned AccW      = 64;
  localparam int unsigned CountW    = 13;
  localparam int unsigned RadixW    = 6;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned DataW     = 32;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned RegIdxLsb = 2;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned MaxCharsDefault = 4096;

  localparam logic [0:0] RegRadix      = 1'b0;
  localparam logic [0:0] RegSignedMode = 1'b1;

  localparam logic [RadixW-1:0] RadixReset  = 6'd10;
  localparam logic              SignedReset = 1'b1;

  localparam logic [RadixW-1:0] BaseAuto  = 6'd0;
  localparam logic [RadixW-1:0] BaseMin   = 6'd2;
  localparam logic [RadixW-1:0] BaseOctal = 6'd8;
  localparam logic [RadixW-1:0] BaseDec   = 6'd10;
  localparam logic [RadixW-1:0] BaseHex   = 6'd16;

  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] HexTen    = 8'd10;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       final_char;
  } atip_in_t;

  typedef struct packed {
    logic [AccW-1:0]   parsed_value;
    logic [CountW-1:0] consumed_count;
  } atip_out_t;

  typedef struct packed {
    logic              final_char;
    logic              is_space;
    logic              is_sign;
    logic              is_minus;
    logic              is_zero;
    logic              is_x;
    logic              dec_ok;
    logic              hex_ok;
    logic [DigitW-1:0] digit_val;
  } atip_class_t;

  typedef struct packed {
    logic valid;
    logic full;
  } atip_qstat_t;

  typedef enum logic [2:0] {
    PhSpace,
    PhPrefix,
    PhZero,
    PhDigits,
    PhStop
  } atip_phase_e;

endpackage

/* design/atip_front.sv */
// ----------------------------------------------------------------------------
// atip_front
// Input handshake and per-character classification.
// ----------------------------------------------------------------------------
module atip_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  atip_pkg::atip_in_t    in_data_i,
  input  atip_pkg::atip_qstat_t qstat_i,
  output logic                  push_o,
  output atip_pkg::atip_class_t entry_o
);

  logic [7:0] c;
  logic       is_dec;
  logic       is_low;
  logic       is_up;
  logic [7:0] dval;

  assign c = in_data_i.ascii_char;

  always_comb begin
    is_dec = (c >= atip_pkg::CharZero) && (c <= atip_pkg::CharNine);
    is_low = (c >= atip_pkg::CharLowA) && (c <= atip_pkg::CharLowF);
    is_up  = (c >= atip_pkg::CharUpA) && (c <= atip_pkg::CharUpF);
    if (is_low) begin
      dval = c - atip_pkg::CharLowA + atip_pkg::HexTen;
    end else if (is_up) begin
      dval = c - atip_pkg::CharUpA + atip_pkg::HexTen;
    end else begin
      dval = c - atip_pkg::CharZero;
    end
    entry_o.final_char = in_data_i.final_char;
    entry_o.is_space   = (c == atip_pkg::CharSpace) ||
                         ((c >= atip_pkg::CharTab) && (c <= atip_pkg::CharCr));
    entry_o.is_sign    = (c == atip_pkg::CharPlus) || (c == atip_pkg::CharMinus);
    entry_o.is_minus   = (c == atip_pkg::CharMinus);
    entry_o.is_zero    = (c == atip_pkg::CharZero);
    entry_o.is_x       = (c == atip_pkg::CharLowX);
    entry_o.dec_ok     = is_dec;
    entry_o.hex_ok     = is_dec || is_low || is_up;
    entry_o.digit_val  = dval[atip_pkg::DigitW-1:0];
  end

  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

endmodule

/* design/atip_queue.sv */
// ----------------------------------------------------------------------------
// atip_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module atip_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  atip_pkg::atip_class_t entry_i,
  input  logic                  pop_i,
  output atip_pkg::atip_class_t entry_o,
  output atip_pkg::atip_qstat_t qstat_o
);

  localparam int unsigned PtrW = (atip_pkg::QDepth > 1) ? $clog2(atip_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(atip_pkg::QDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(atip_pkg::QDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(atip_pkg::QDepth);

  atip_pkg::atip_class_t mem_q [atip_pkg::QDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  assign entry_o       = mem_q[rptr_q];
  assign qstat_o.valid = (cnt_q != '0);
  assign qstat_o.full  = (cnt_q == CntFull);

endmodule

/* design/atip_back.sv */
// ----------------------------------------------------------------------------
// atip_back
// Parse sequencer: sign, prefix and digit accumulation, result register.
// ----------------------------------------------------------------------------
module atip_back #(
  parameter int unsigned MaxChars = atip_pkg::MaxCharsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [atip_pkg::RadixW-1:0]   radix_i,
  input  logic                          signed_mode_i,
  input  atip_pkg::atip_qstat_t         qstat_i,
  input  atip_pkg::atip_class_t         entry_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output atip_pkg::atip_out_t           out_data_o
);

  localparam int unsigned CntW = $clog2(MaxChars + 1);
  localparam int unsigned ExtW = (CntW > atip_pkg::CountW) ? CntW : atip_pkg::CountW;
  localparam logic [CntW:0] SatMax = (CntW + 1)'(MaxChars);

  atip_pkg::atip_phase_e phase_q, phase_d;
  logic [atip_pkg::RadixW-1:0] base_q, base_d;
  logic                        minus_q, minus_d;
  logic [atip_pkg::AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        out_valid_q;
  atip_pkg::atip_out_t         out_q;

  logic [atip_pkg::RadixW-1:0] pre_base;
  logic [atip_pkg::RadixW-1:0] dig_base;
  logic                        do_pre;
  logic                        take_dig;
  logic                        dig_ok;
  logic [1:0]                  inc;
  logic [CntW:0]               cnt_sum;
  logic [atip_pkg::AccW-1:0]   mac;
  logic [atip_pkg::AccW-1:0]   value;
  logic [ExtW-1:0]             cnt_ext;

  assign pop_o = qstat_i.valid && (!entry_i.final_char || !out_valid_q || out_ready_i);

  always_comb begin
    phase_d  = phase_q;
    base_d   = base_q;
    minus_d  = minus_q;
    acc_d    = acc_q;
    inc      = 2'd0;
    do_pre   = 1'b0;
    take_dig = 1'b0;
    dig_base = base_q;
    pre_base = (phase_q == atip_pkg::PhSpace) ? radix_i : base_q;

    case (phase_q)
      atip_pkg::PhSpace: begin
        if (entry_i.is_space) begin
          inc = 2'd1;
        end else begin
          base_d  = radix_i;
          phase_d = atip_pkg::PhPrefix;
          if (entry_i.is_sign) begin
            minus_d = signed_mode_i && entry_i.is_minus;
            inc     = 2'd1;
          end else begin
            do_pre = 1'b1;
          end
        end
      end
      atip_pkg::PhPrefix: begin
        do_pre = 1'b1;
      end
      atip_pkg::PhZero: begin
        if (entry_i.is_x) begin
          base_d  = atip_pkg::BaseHex;
          inc     = 2'd2;
          phase_d = atip_pkg::PhDigits;
        end else begin
          if (base_q == atip_pkg::BaseAuto) begin
            base_d = atip_pkg::BaseOctal;
          end
          inc      = 2'd1;
          phase_d  = atip_pkg::PhDigits;
          take_dig = 1'b1;
          dig_base = base_d;
        end
      end
      atip_pkg::PhDigits: begin
        take_dig = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_pre) begin
      if (((pre_base == atip_pkg::BaseAuto) || (pre_base == atip_pkg::BaseHex)) &&
          entry_i.is_zero && !entry_i.final_char) begin
        phase_d = atip_pkg::PhZero;
      end else if ((pre_base == atip_pkg::BaseAuto) && entry_i.is_zero) begin
        base_d  = atip_pkg::BaseOctal;
        inc     = inc + 2'd1;
        phase_d = atip_pkg::PhStop;
      end else begin
        base_d   = (pre_base == atip_pkg::BaseAuto) ? atip_pkg::BaseDec : pre_base;
        phase_d  = atip_pkg::PhDigits;
        take_dig = 1'b1;
        dig_base = base_d;
      end
    end

    dig_ok = ((dig_base inside {[atip_pkg::BaseMin:atip_pkg::BaseDec]}) && entry_i.dec_ok &&
              (atip_pkg::RadixW'(entry_i.digit_val) < dig_base)) ||
             ((dig_base == atip_pkg::BaseHex) && entry_i.hex_ok);
    mac = acc_q * atip_pkg::AccW'(dig_base) + atip_pkg::AccW'(entry_i.digit_val);

    if (take_dig) begin
      if (dig_ok) begin
        acc_d = mac;
        inc   = inc + 2'd1;
      end else begin
        phase_d = atip_pkg::PhStop;
      end
    end

    cnt_sum = {1'b0, cnt_q} + (CntW + 1)'(inc);
    cnt_d   = (cnt_sum > SatMax) ? SatMax[CntW-1:0] : cnt_sum[CntW-1:0];
    value   = minus_d ? (~acc_d + 1'b1) : acc_d;
    cnt_ext = ExtW'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= atip_pkg::PhSpace;
      base_q  <= atip_pkg::BaseAuto;
      minus_q <= 1'b0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (pop_o) begin
      if (entry_i.final_char) begin
        phase_q <= atip_pkg::PhSpace;
        base_q  <= atip_pkg::BaseAuto;
        minus_q <= 1'b0;
        acc_q   <= '0;
        cnt_q   <= '0;
      end else begin
        phase_q <= phase_d;
        base_q  <= base_d;
        minus_q <= minus_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && entry_i.final_char) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.final_char) begin
      out_q.parsed_value   <= value;
      out_q.consumed_count <= cnt_ext[atip_pkg::CountW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/ascii_to_integer_parser_top.sv */
// ----------------------------------------------------------------------------
// ascii_to_integer_parser_top
// Streaming string-to-integer parser with APB register port.
// ----------------------------------------------------------------------------
//   channel  | signals                         | beat
//   ---------+---------------------------------+------------------------------
//   in       | in_valid_i/in_ready_o/in_data_i | one character, final flag
//   out      | out_valid_o/out_ready_i/out_data_o | value and consumed count
//   cfg      | psel/penable/pwrite/paddr/...   | radix at 0x0, signed_mode at 0x4
//
// One character per cycle sustained while the output takes results; the 64-bit
// multiply-add of the accumulator by the base in the back sequencer sets the cycle.
// A final character is written into the queue, popped by the back sequencer and registered as the result.
// A two-entry queue parts input acceptance from parsing; the result register
// parts parsing from the output, so either side may stall independently.
// Reset restores radix 10, signed_mode 1 and an empty parse; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ascii_to_integer_parser_top #(
  parameter int unsigned MaxChars = atip_pkg::MaxCharsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  atip_pkg::atip_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output atip_pkg::atip_out_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [atip_pkg::PaddrW-1:0]   paddr,
  input  logic [atip_pkg::DataW-1:0]    pwdata,
  output logic [atip_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  logic [atip_pkg::RadixW-1:0] radix_q;
  logic                        signed_mode_q;
  logic [0:0]                  reg_idx;
  logic                        cfg_we;

  logic                  push;
  logic                  pop;
  atip_pkg::atip_class_t front_entry;
  atip_pkg::atip_class_t q_entry;
  atip_pkg::atip_qstat_t qstat;

  assign reg_idx = paddr[atip_pkg::RegIdxLsb];
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= atip_pkg::RadixReset;
      signed_mode_q <= atip_pkg::SignedReset;
    end else if (cfg_we) begin
      case (reg_idx)
        atip_pkg::RegRadix:      radix_q       <= pwdata[atip_pkg::RadixW-1:0];
        atip_pkg::RegSignedMode: signed_mode_q <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      atip_pkg::RegRadix:      prdata = atip_pkg::DataW'(radix_q);
      atip_pkg::RegSignedMode: prdata = atip_pkg::DataW'(signed_mode_q);
      default:                 prdata = '0;
    endcase
  end

  atip_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .entry_o    (front_entry)
  );

  atip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .entry_o (q_entry),
    .qstat_o (qstat)
  );

  atip_back #(
    .MaxChars (MaxChars)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .radix_i       (radix_q),
    .signed_mode_i (signed_mode_q),
    .qstat_i       (qstat),
    .entry_i       (q_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

  `ATIP_ASSERT_IMP(a_final_pop_slot, clk_i, rst_ni, pop && q_entry.final_char, !out_valid_o || out_ready_i, "final beat popped while result slot busy")
  `ATIP_ASSERT_NXT(a_out_drain, clk_i, rst_ni, out_valid_o && out_ready_i && !(pop && q_entry.final_char), !out_valid_o, "result slot not released after beat")
  `ATIP_ASSERT_NXT(a_push_lands, clk_i, rst_ni, in_valid_i && in_ready_o, qstat.valid, "accepted beat missing from queue")

endmodule
